### rtl/gch_pkg.sv
// gch_pkg: types, codes and the command byte table of the gpib controller handshake
// no dependencies; used by every file under rtl

package gch_pkg;

    // request kinds
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SEND = 2'd1;
    localparam logic [1:0] MODE_RECV = 2'd2;

    // result status
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_LISTENER = 2'd1;
    localparam logic [1:0] ST_BAD_CMD     = 2'd2;

    // command ids: line sets, interface commands, data byte
    localparam logic [4:0] CID_ATN = 5'd0;
    localparam logic [4:0] CID_EOI = 5'd4;
    localparam logic [4:0] CID_MLA = 5'd5;
    localparam logic [4:0] CID_MTA = 5'd6;
    localparam logic [4:0] CID_LAD = 5'd7;
    localparam logic [4:0] CID_UNL = 5'd8;
    localparam logic [4:0] CID_TAD = 5'd9;
    localparam logic [4:0] CID_UNT = 5'd10;
    localparam logic [4:0] CID_SAD = 5'd11;
    localparam logic [4:0] CID_LLO = 5'd12;
    localparam logic [4:0] CID_DCL = 5'd13;
    localparam logic [4:0] CID_PPU = 5'd14;
    localparam logic [4:0] CID_SPE = 5'd15;
    localparam logic [4:0] CID_SPD = 5'd16;
    localparam logic [4:0] CID_GTL = 5'd17;
    localparam logic [4:0] CID_SDC = 5'd18;
    localparam logic [4:0] CID_PPC = 5'd19;
    localparam logic [4:0] CID_GET = 5'd20;
    localparam logic [4:0] CID_TCT = 5'd21;
    localparam logic [4:0] CID_PPE = 5'd22;
    localparam logic [4:0] CID_PPD = 5'd23;
    localparam logic [4:0] CID_DATA = 5'd24;

    // line and handshake bit masks
    localparam logic [4:0] LN_ATN  = 5'b00001;
    localparam logic [2:0] HS_DAV  = 3'b001;
    localparam logic [2:0] HS_NRFD = 3'b010;
    localparam logic [2:0] HS_NDAC = 3'b100;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TX_NRFD,
        PH_TX_NDAC,
        PH_RX_DAV,
        PH_RX_DAVLOW
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] command_id;
        logic [7:0] arg;
        logic       bus_nrfd;
        logic       bus_ndac;
        logic       bus_dav;
        logic [7:0] bus_data_in;
    } t_in_item;

    typedef struct packed {
        logic [4:0] control_lines;
        logic [2:0] handshake_drive;
        logic [7:0] bus_data_out;
        logic       talker_dir;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] received_byte;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] out_byte;
        logic [4:0] line_levels;
        logic [2:0] hs_levels;
        logic       talking;
        logic       cmd_cycle;
        logic [7:0] rx_byte;
    } t_state;

    // interface command byte for ids MLA..PPD; address commands wrap mod 256
    function automatic logic [7:0] cmd_code(input logic [4:0] cid, input logic [7:0] arg);
        logic [7:0] code;
        unique case (cid)
            CID_MLA: code = 8'h20;
            CID_MTA: code = 8'h40;
            CID_LAD: code = 8'h20 + arg;
            CID_UNL: code = 8'h3F;
            CID_TAD: code = 8'h40 + arg;
            CID_UNT: code = 8'h5F;
            CID_SAD: code = 8'h60 + arg;
            CID_LLO: code = 8'h11;
            CID_DCL: code = 8'h14;
            CID_PPU: code = 8'h15;
            CID_SPE: code = 8'h18;
            CID_SPD: code = 8'h19;
            CID_GTL: code = 8'h01;
            CID_SDC: code = 8'h04;
            CID_PPC: code = 8'h05;
            CID_GET: code = 8'h08;
            CID_TCT: code = 8'h09;
            CID_PPE: code = 8'h60;
            CID_PPD: code = 8'h70;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

### rtl/gch_step.sv
// gch_step: next state and result for one transaction of the handshake controller
// depends on gch_pkg

module gch_step (
    input  gch_pkg::t_state    i_state,
    input  gch_pkg::t_in_item  i_item,
    output gch_pkg::t_state    o_state,
    output gch_pkg::t_out_item o_result
);

    gch_pkg::t_phase n_phase;
    gch_pkg::t_state n_state;
    logic            listener;
    logic            is_cmd;
    logic            done;
    logic [1:0]      status;

    assign listener = i_item.bus_nrfd | i_item.bus_ndac;
    assign is_cmd   = (i_item.command_id >= gch_pkg::CID_MLA) &&
                      (i_item.command_id <= gch_pkg::CID_PPD);

    // next phase
    always_comb begin
        n_phase = i_state.phase;
        unique case (i_state.phase)
            gch_pkg::PH_IDLE: begin
                if (i_item.mode == gch_pkg::MODE_SEND) begin
                    if ((is_cmd || i_item.command_id == gch_pkg::CID_DATA) && listener)
                        n_phase = gch_pkg::PH_TX_NRFD;
                end else if (i_item.mode == gch_pkg::MODE_RECV) begin
                    n_phase = gch_pkg::PH_RX_DAV;
                end
            end
            gch_pkg::PH_TX_NRFD:   if (!i_item.bus_nrfd) n_phase = gch_pkg::PH_TX_NDAC;
            gch_pkg::PH_TX_NDAC:   if (!i_item.bus_ndac) n_phase = gch_pkg::PH_IDLE;
            gch_pkg::PH_RX_DAV:    if (i_item.bus_dav)   n_phase = gch_pkg::PH_RX_DAVLOW;
            gch_pkg::PH_RX_DAVLOW: if (!i_item.bus_dav)  n_phase = gch_pkg::PH_IDLE;
            default:               n_phase = gch_pkg::PH_IDLE;
        endcase
    end

    // line levels, handshake drives and latched bytes
    always_comb begin
        n_state = i_state;
        done    = 1'b0;
        status  = gch_pkg::ST_OK;
        unique case (i_state.phase)
            gch_pkg::PH_IDLE: begin
                if (i_item.mode == gch_pkg::MODE_SEND) begin
                    done = 1'b1;
                    if (i_item.command_id <= gch_pkg::CID_EOI) begin
                        if (i_item.arg != 8'd0)
                            n_state.line_levels[i_item.command_id[2:0]] = 1'b1;
                        else
                            n_state.line_levels[i_item.command_id[2:0]] = 1'b0;
                    end else if (is_cmd || i_item.command_id == gch_pkg::CID_DATA) begin
                        n_state.talking   = 1'b1;
                        n_state.hs_levels = 3'b000;
                        if (listener) begin
                            done = 1'b0;
                            n_state.out_byte = is_cmd ?
                                gch_pkg::cmd_code(i_item.command_id, i_item.arg) :
                                i_item.arg;
                            // commands go out under atn, data with atn released
                            n_state.line_levels = is_cmd ?
                                (i_state.line_levels | gch_pkg::LN_ATN) :
                                (i_state.line_levels & ~gch_pkg::LN_ATN);
                            n_state.cmd_cycle = is_cmd;
                        end else begin
                            status = gch_pkg::ST_NO_LISTENER;
                            n_state.line_levels = i_state.line_levels & ~gch_pkg::LN_ATN;
                            n_state.cmd_cycle   = 1'b0;
                        end
                    end else begin
                        status = gch_pkg::ST_BAD_CMD;
                    end
                end else if (i_item.mode == gch_pkg::MODE_RECV) begin
                    n_state.talking   = 1'b0;
                    n_state.hs_levels = gch_pkg::HS_NDAC;
                end
            end
            gch_pkg::PH_TX_NRFD: begin
                if (!i_item.bus_nrfd)
                    n_state.hs_levels = i_state.hs_levels | gch_pkg::HS_DAV;
            end
            gch_pkg::PH_TX_NDAC: begin
                if (!i_item.bus_ndac) begin
                    n_state.hs_levels = i_state.hs_levels & ~gch_pkg::HS_DAV;
                    if (i_state.cmd_cycle) begin
                        n_state.line_levels = i_state.line_levels & ~gch_pkg::LN_ATN;
                        n_state.cmd_cycle   = 1'b0;
                    end
                    done = 1'b1;
                end
            end
            gch_pkg::PH_RX_DAV: begin
                if (i_item.bus_dav) begin
                    n_state.rx_byte   = i_item.bus_data_in;
                    n_state.hs_levels = gch_pkg::HS_NRFD;
                end
            end
            gch_pkg::PH_RX_DAVLOW: begin
                if (!i_item.bus_dav) begin
                    n_state.hs_levels = i_state.hs_levels | gch_pkg::HS_NDAC;
                    done = 1'b1;
                end
            end
            default: ;
        endcase
        n_state.phase = n_phase;
    end

    assign o_state = n_state;

    always_comb begin
        o_result.control_lines   = n_state.line_levels;
        o_result.handshake_drive = n_state.hs_levels;
        o_result.bus_data_out    = n_state.talking ? n_state.out_byte : 8'd0;
        o_result.talker_dir      = n_state.talking;
        o_result.busy_res        = (n_phase != gch_pkg::PH_IDLE);
        o_result.done_res        = done;
        o_result.status          = status;
        o_result.received_byte   = n_state.rx_byte;
    end

endmodule

### rtl/gpib_controller_handshake_top.sv
// gpib_controller_handshake_top: ieee 488 controller three-wire handshake, one result per tick
// depends on gch_pkg and gch_step

// Each accepted transaction is one bus tick: its request and sampled NRFD, NDAC, DAV
// and DIO lines advance the controller by one step, and exactly one result comes
// back, held in an output register that is loaded on acceptance. A new transaction can
// be taken every cycle; the only thing that holds the input back is a full output
// register whose result has not yet been taken.
module gpib_controller_handshake_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gch_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gch_pkg::t_out_item o_out
);

    gch_pkg::t_state    r_state;
    gch_pkg::t_state    n_state;
    gch_pkg::t_out_item r_out;
    gch_pkg::t_out_item n_out;
    logic               r_out_valid;
    logic               accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    gch_step u_step (
        .i_state  (r_state),
        .i_item   (i_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= gch_pkg::PH_IDLE;
            r_state.out_byte    <= 8'd0;
            r_state.line_levels <= 5'd0;
            r_state.hs_levels   <= 3'd0;
            r_state.talking     <= 1'b0;
            r_state.cmd_cycle   <= 1'b0;
            r_state.rx_byte     <= 8'd0;
            r_out_valid         <= 1'b0;
        end else begin
            if (accept)
                r_state <= n_state;
            if (accept)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/gch_checker.sv
// gch_assertions: port-level checks on the handshake controller, bound to the top level
// depends on gch_pkg

module gch_assertions (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input gch_pkg::t_out_item i_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result changed while stalled");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output register");

    // a non-ok status only comes with a finished request
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.status != gch_pkg::ST_OK |-> i_out.done_res)
        else $error("status without done");

    // a finished request leaves the controller idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.done_res |-> !i_out.busy_res)
        else $error("done while busy");

    // the dio lines are only driven when talking
    a_listen_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out.talker_dir |-> i_out.bus_data_out == 8'd0)
        else $error("data driven as listener");

endmodule

bind gpib_controller_handshake_top gch_assertions u_gch_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

### sim/gch_checker.sv
// gch_checker: watches both channels of the gpib controller handshake, predicts each
// result from the accepted bus ticks and compares field by field
// depends on gch_pkg

module gch_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  gch_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  gch_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // base byte of each interface command, MLA at index 0 up to PPD at index 18
    localparam logic [18:0][7:0] CMD_BASE = {
        8'h70, 8'h60, 8'h09, 8'h08, 8'h05, 8'h04, 8'h01, 8'h19, 8'h18, 8'h15,
        8'h14, 8'h11, 8'h60, 8'h5F, 8'h40, 8'h3F, 8'h20, 8'h40, 8'h20
    };

    // predicted controller state
    gch_pkg::t_phase ph;
    logic [7:0]      tx_byte;
    logic [4:0]      lines;
    logic [2:0]      hs_drive;
    logic            talking;
    logic            cmd_cycle;
    logic [7:0]      rx_byte;

    gch_pkg::t_out_item expected_q[$];
    gch_pkg::t_out_item want;
    int                 fail_count = 0;
    int                 checked_count = 0;
    int                 pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;
    assign o_pending    = pending_count;

    function automatic logic [7:0] command_byte(input logic [4:0] cid, input logic [7:0] arg);
        logic [4:0] idx;
        logic [7:0] code;
        idx  = cid - gch_pkg::CID_MLA;
        code = CMD_BASE[idx];
        // address commands carry the offset, wrapping at 8 bits
        if (cid == gch_pkg::CID_LAD || cid == gch_pkg::CID_TAD || cid == gch_pkg::CID_SAD)
            code = code + arg;
        return code;
    endfunction

    // start of a talker transaction; low when nobody is listening
    function automatic logic begin_talk(input logic [7:0] code, input logic nrfd,
                                        input logic ndac);
        talking  = 1'b1;
        hs_drive = '0;
        if (!nrfd && !ndac) begin
            if (cmd_cycle) begin
                lines     = lines & ~gch_pkg::LN_ATN;
                cmd_cycle = 1'b0;
            end
            return 1'b0;
        end
        tx_byte = code;
        ph      = gch_pkg::PH_TX_NRFD;
        return 1'b1;
    endfunction

    function automatic gch_pkg::t_out_item advance_bus(input gch_pkg::t_in_item it);
        gch_pkg::t_out_item r;
        logic               done;
        logic [1:0]         st;
        done = 1'b0;
        st   = gch_pkg::ST_OK;
        case (ph)
            gch_pkg::PH_IDLE: begin
                if (it.mode == gch_pkg::MODE_SEND) begin
                    done = 1'b1;
                    if (it.command_id <= gch_pkg::CID_EOI) begin
                        lines[it.command_id] = (it.arg != 8'h00);
                    end else if (it.command_id <= gch_pkg::CID_PPD) begin
                        lines     = lines | gch_pkg::LN_ATN;
                        cmd_cycle = 1'b1;
                        if (begin_talk(command_byte(it.command_id, it.arg),
                                       it.bus_nrfd, it.bus_ndac))
                            done = 1'b0;
                        else
                            st = gch_pkg::ST_NO_LISTENER;
                    end else if (it.command_id == gch_pkg::CID_DATA) begin
                        lines     = lines & ~gch_pkg::LN_ATN;
                        cmd_cycle = 1'b0;
                        if (begin_talk(it.arg, it.bus_nrfd, it.bus_ndac))
                            done = 1'b0;
                        else
                            st = gch_pkg::ST_NO_LISTENER;
                    end else begin
                        st = gch_pkg::ST_BAD_CMD;
                    end
                end else if (it.mode == gch_pkg::MODE_RECV) begin
                    // turning listener drops the dav drive
                    talking  = 1'b0;
                    hs_drive = gch_pkg::HS_NDAC;
                    ph       = gch_pkg::PH_RX_DAV;
                end
            end
            gch_pkg::PH_TX_NRFD: begin
                if (!it.bus_nrfd) begin
                    hs_drive = hs_drive | gch_pkg::HS_DAV;
                    ph       = gch_pkg::PH_TX_NDAC;
                end
            end
            gch_pkg::PH_TX_NDAC: begin
                if (!it.bus_ndac) begin
                    hs_drive = hs_drive & ~gch_pkg::HS_DAV;
                    if (cmd_cycle) begin
                        lines     = lines & ~gch_pkg::LN_ATN;
                        cmd_cycle = 1'b0;
                    end
                    ph   = gch_pkg::PH_IDLE;
                    done = 1'b1;
                end
            end
            gch_pkg::PH_RX_DAV: begin
                if (it.bus_dav) begin
                    rx_byte  = it.bus_data_in;
                    hs_drive = gch_pkg::HS_NRFD;
                    ph       = gch_pkg::PH_RX_DAVLOW;
                end
            end
            gch_pkg::PH_RX_DAVLOW: begin
                if (!it.bus_dav) begin
                    hs_drive = hs_drive | gch_pkg::HS_NDAC;
                    ph       = gch_pkg::PH_IDLE;
                    done     = 1'b1;
                end
            end
            default: ph = gch_pkg::PH_IDLE;
        endcase
        r.control_lines   = lines;
        r.handshake_drive = hs_drive;
        r.bus_data_out    = talking ? tx_byte : 8'h00;
        r.talker_dir      = talking;
        r.busy_res        = (ph != gch_pkg::PH_IDLE);
        r.done_res        = done;
        r.status          = st;
        r.received_byte   = rx_byte;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph        = gch_pkg::PH_IDLE;
            tx_byte   = '0;
            lines     = '0;
            hs_drive  = '0;
            talking   = 1'b0;
            cmd_cycle = 1'b0;
            rx_byte   = '0;
            expected_q.delete();
            pending_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_q.push_back(advance_bus(i_in));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected, got %h", $time, i_out);
                end else begin
                    want = expected_q.pop_front();
                    check_field("control_lines", want.control_lines, i_out.control_lines);
                    check_field("handshake_drive", want.handshake_drive,
                                i_out.handshake_drive);
                    check_field("bus_data_out", want.bus_data_out, i_out.bus_data_out);
                    check_field("talker_dir", want.talker_dir, i_out.talker_dir);
                    check_field("busy_res", want.busy_res, i_out.busy_res);
                    check_field("done_res", want.done_res, i_out.done_res);
                    check_field("status", want.status, i_out.status);
                    check_field("received_byte", want.received_byte, i_out.received_byte);
                    checked_count++;
                end
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

### sim/tb_top.sv
// tb_top: stimulus, clock, reset, idling and verdict for gpib_controller_handshake_top
// depends on gch_pkg, gch_checker and the rtl under test

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [4:0] CID_FIRST_BAD = gch_pkg::CID_DATA + 5'd1;
    localparam logic [4:0] CID_LAST_BAD  = 5'd31;
    localparam int         PHASE_TICKS   = 400;
    localparam int         STALL_LIMIT   = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    gch_pkg::t_in_item  i_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    gch_pkg::t_out_item o_out;

    int         fail_count;
    int         pending;
    int         checked;
    int         n_sent = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles = 0;

    int         send_idle_mix[4]  = '{0, 48, 0, 14};
    int         recv_stall_mix[4] = '{0, 0, 48, 14};

    gpib_controller_handshake_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    gch_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("[gpib_controller_handshake_top] ERROR");
                $finish;
            end
        end
    end

    function automatic gch_pkg::t_in_item make_item(input logic [1:0] mode,
                                                    input logic [4:0] cid,
                                                    input logic [7:0] arg, input logic nrfd,
                                                    input logic ndac, input logic dav,
                                                    input logic [7:0] din);
        gch_pkg::t_in_item it;
        it.mode        = mode;
        it.command_id  = cid;
        it.arg         = arg;
        it.bus_nrfd    = nrfd;
        it.bus_ndac    = ndac;
        it.bus_dav     = dav;
        it.bus_data_in = din;
        return it;
    endfunction

    function automatic gch_pkg::t_in_item noise_item();
        return make_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
    endfunction

    // tick inside a running handshake: mostly no request, now and then a stray one
    function automatic gch_pkg::t_in_item busy_tick();
        gch_pkg::t_in_item it;
        it = noise_item();
        if ($urandom_range(0, 3) != 0)
            it.mode = gch_pkg::MODE_NONE;
        return it;
    endfunction

    task automatic put_item(input gch_pkg::t_in_item it);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // hold the sender back until every outstanding result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_sequence();
        gch_pkg::t_in_item it;
        int                waits;
        logic              talk;
        it      = noise_item();
        it.mode = gch_pkg::MODE_SEND;
        case ($urandom_range(0, 9))
            0, 1:       it.command_id = 5'($urandom_range(gch_pkg::CID_ATN, gch_pkg::CID_EOI));
            2:          it.command_id = 5'($urandom_range(CID_FIRST_BAD, CID_LAST_BAD));
            3, 4, 5, 6: it.command_id = 5'($urandom_range(gch_pkg::CID_MLA, gch_pkg::CID_PPD));
            default:    it.command_id = gch_pkg::CID_DATA;
        endcase
        if ($urandom_range(0, 7) == 0)
            {it.bus_nrfd, it.bus_ndac} = 2'b00;
        else
            {it.bus_nrfd, it.bus_ndac} = 2'($urandom_range(1, 3));
        talk = (it.command_id >= gch_pkg::CID_MLA) && (it.command_id <= gch_pkg::CID_DATA) &&
               (it.bus_nrfd || it.bus_ndac);
        put_item(it);
        if (talk) begin
            waits = $urandom_range(0, 3);
            repeat (waits) begin
                it = busy_tick();
                it.bus_nrfd = 1'b1;
                put_item(it);
            end
            it = busy_tick();
            it.bus_nrfd = 1'b0;
            put_item(it);
            waits = $urandom_range(0, 3);
            repeat (waits) begin
                it = busy_tick();
                it.bus_ndac = 1'b1;
                put_item(it);
            end
            it = busy_tick();
            it.bus_ndac = 1'b0;
            put_item(it);
        end
    endtask

    task automatic receive_sequence();
        gch_pkg::t_in_item it;
        int                waits;
        it      = noise_item();
        it.mode = gch_pkg::MODE_RECV;
        put_item(it);
        waits = $urandom_range(0, 3);
        repeat (waits) begin
            it = busy_tick();
            it.bus_dav = 1'b0;
            put_item(it);
        end
        it = busy_tick();
        it.bus_dav = 1'b1;
        put_item(it);
        waits = $urandom_range(0, 3);
        repeat (waits) begin
            it = busy_tick();
            it.bus_dav = 1'b1;
            put_item(it);
        end
        it = busy_tick();
        it.bus_dav = 1'b0;
        put_item(it);
    endtask

    task automatic random_ticks(input int target);
        int r;
        while (n_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_sequence();
            else if (r < 75)
                receive_sequence();
            else
                repeat ($urandom_range(1, 3)) put_item(noise_item());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every control line set, then bad ids and the unused mode
        for (int c = gch_pkg::CID_ATN; c <= gch_pkg::CID_EOI; c++)
            put_item(make_item(gch_pkg::MODE_SEND, 5'(c), 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00));
        put_item(make_item(gch_pkg::MODE_SEND, CID_FIRST_BAD, 8'h00, 1'b1, 1'b1, 1'b1, 8'hFF));
        put_item(make_item(gch_pkg::MODE_SEND, CID_LAST_BAD, 8'hFF, 1'b0, 1'b1, 1'b0, 8'h00));
        put_item(make_item(MODE_UNUSED, gch_pkg::CID_DATA, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
        // secondary address wrapping past 0xff, with a request arriving mid transaction
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_SAD, 8'hFF, 1'b1, 1'b1, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_RECV, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b1, 1'b1,
                           8'hFF));
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_DATA, 8'h00, 1'b1, 1'b1, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b1, 1'b0, 1'b0,
                           8'h00));
        // talk address with nobody listening drops atn
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_TAD, 8'h1F, 1'b0, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_DATA, 8'h00, 1'b0, 1'b1, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b1, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_DATA, 8'hFF, 1'b1, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_DATA, 8'h5A, 1'b0, 1'b0, 1'b1,
                           8'h00));
        // listener transaction latching an all-ones byte
        put_item(make_item(gch_pkg::MODE_RECV, gch_pkg::CID_DATA, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'hFF));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b1,
                           8'hFF));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b1,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_NONE, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_ATN, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'h00));
        put_item(make_item(gch_pkg::MODE_SEND, gch_pkg::CID_EOI, 8'h00, 1'b0, 1'b0, 1'b0,
                           8'h00));
        drain_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_idle_mix[p];
            recv_stall_pct = recv_stall_mix[p];
            random_ticks(n_sent + PHASE_TICKS / 2);
            drain_results();
            random_ticks(n_sent + PHASE_TICKS / 2);
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d bus ticks: line sets, every interface command, data, receives,",
                 n_sent);
        $display("bad ids and missing listeners under four idling mixes; %0d results compared",
                 checked);
        if (fail_count == 0)
            $display("[gpib_controller_handshake_top] OK");
        else
            $display("[gpib_controller_handshake_top] ERROR");
        $finish;
    end

endmodule
